// ===== rtl/sotd_pkg.sv =====
// Package: item types, opcode and phase codes, character codes and trie table for the decoder.
package sotd_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic [4:0]         opcode;
        logic signed [31:0] argument;
        logic               has_argument;
        logic               error;
        logic               done_res;
    } result_t;

    typedef enum logic [4:0] {
        OP_PUSH, OP_DUP, OP_COPY, OP_SWAP, OP_DISCARD, OP_SLIDE,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_HEAPW, OP_HEAPR,
        OP_LABEL, OP_CALL, OP_JUMP, OP_JZ, OP_JN, OP_RET, OP_EXIT,
        OP_CHOUT, OP_NUMOUT
    } op_t;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_SIGN,
        PH_BITS,
        PH_SWALLOW
    } phase_t;

    typedef enum logic [1:0] {
        COL_SPACE,
        COL_A,
        COL_AT,
        COL_NONE
    } col_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_G     = 8'h67;

    localparam logic [7:0] LEAF = 8'h20;
    localparam logic [7:0] BAD  = 8'hFF;

    // columns: ' ', 'a', '@'
    localparam logic [7:0] TRIE_TAB [16][3] = '{
        '{8'd12,             8'd1,               8'd4              },
        '{8'd2,              LEAF | 8'(OP_PUSH), 8'd3              },
        '{LEAF | 8'(OP_DISCARD), LEAF | 8'(OP_DUP), LEAF | 8'(OP_SWAP)},
        '{LEAF | 8'(OP_SLIDE),   LEAF | 8'(OP_COPY), BAD           },
        '{8'd7,              8'd5,               8'd6              },
        '{BAD,               8'd8,               8'd9              },
        '{8'd10,             BAD,                LEAF | 8'(OP_HEAPR)},
        '{BAD,               8'd11,              BAD               },
        '{LEAF | 8'(OP_MUL), LEAF | 8'(OP_ADD),  LEAF | 8'(OP_SUB) },
        '{BAD,               LEAF | 8'(OP_DIV),  LEAF | 8'(OP_MOD) },
        '{LEAF | 8'(OP_HEAPW), BAD,              BAD               },
        '{BAD,               LEAF | 8'(OP_CHOUT), LEAF | 8'(OP_NUMOUT)},
        '{8'd15,             8'd13,              8'd14             },
        '{LEAF | 8'(OP_JUMP), LEAF | 8'(OP_LABEL), LEAF | 8'(OP_CALL)},
        '{LEAF | 8'(OP_RET), LEAF | 8'(OP_JZ),   LEAF | 8'(OP_JN)  },
        '{LEAF | 8'(OP_EXIT), BAD,               BAD               }
    };

    function automatic logic takes_number(input logic [4:0] op);
        takes_number = (op == OP_PUSH) || (op == OP_COPY) || (op == OP_SLIDE)
            || (op == OP_LABEL) || (op == OP_CALL) || (op == OP_JUMP)
            || (op == OP_JZ) || (op == OP_JN);
    endfunction

endpackage

// ===== rtl/stack_op_token_decoder_unit.sv =====
// Top level: character-stream decoder of stack-machine opcodes and numeric arguments.
//
// Takes one source character per item and returns at most one result per item.
// Throughput is one character per clock unless the output register stalls:
// each item passes an input register, then the trie step and shift-accumulate,
// and its result is offered from an output register. The input register takes
// a new item whenever it is empty or its item moves on, and its item moves on
// whenever the output register is empty or is being drained.
// Unknown codes and sources that end inside a token give an error result; the
// rest of that source is dropped up to the item marked last.
module stack_op_token_decoder_unit #(
    parameter int ARG_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  sotd_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output sotd_pkg::result_t result
);
    import sotd_pkg::*;

    item_t                 item_reg;
    logic                  item_vld_reg;
    result_t               result_reg;
    logic                  result_vld_reg;

    phase_t                phase_reg, phase_next;
    logic [3:0]            node_reg, node_next;
    logic [4:0]            pend_reg, pend_next;
    logic                  neg_reg, neg_next;
    logic [ARG_WIDTH-1:0]  acc_reg, acc_next;

    logic                  advance;
    logic                  emit;
    logic                  do_fail;
    logic                  do_finish;
    result_t               res;
    col_t                  col;
    logic [7:0]            tcode;
    logic signed [ARG_WIDTH-1:0] num_val;

    assign advance      = item_vld_reg && (!result_vld_reg || result_ready);
    assign item_ready   = !item_vld_reg || advance;
    assign result_valid = result_vld_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (item_reg.symbol == CH_SPACE)
            col = COL_SPACE;
        else if (item_reg.symbol == CH_A)
            col = COL_A;
        else if (item_reg.symbol == CH_AT)
            col = COL_AT;
        else
            col = COL_NONE;
    end

    assign tcode   = (col == COL_NONE) ? BAD : TRIE_TAB[node_reg][col];
    assign num_val = neg_reg ? -acc_reg : acc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        node_next  = node_reg;
        pend_next  = pend_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        do_fail    = 1'b0;
        do_finish  = 1'b0;
        res        = '0;

        case (phase_reg)
            PH_OPCODE:
            begin
                if (tcode == BAD)
                    do_fail = 1'b1;
                else if (!tcode[5])
                begin
                    node_next = tcode[3:0];
                    do_fail   = item_reg.is_last;
                end
                else if (takes_number(tcode[4:0]))
                begin
                    node_next  = '0;
                    pend_next  = tcode[4:0];
                    neg_next   = 1'b0;
                    acc_next   = '0;
                    phase_next = PH_SIGN;
                    do_fail    = item_reg.is_last;
                end
                else
                begin
                    node_next        = '0;
                    pend_next        = '0;
                    neg_next         = 1'b0;
                    acc_next         = '0;
                    phase_next       = PH_OPCODE;
                    emit             = 1'b1;
                    res.opcode       = tcode[4:0];
                    res.done_res     = item_reg.is_last;
                end
            end
            PH_SIGN:
            begin
                if (item_reg.symbol == CH_G)
                    do_finish = 1'b1;
                else
                begin
                    neg_next   = (item_reg.symbol == CH_AT);
                    phase_next = PH_BITS;
                    do_fail    = item_reg.is_last;
                end
            end
            PH_BITS:
            begin
                if (item_reg.symbol == CH_G)
                    do_finish = 1'b1;
                else
                begin
                    acc_next = {acc_reg[ARG_WIDTH-2:0], item_reg.symbol == CH_A};
                    do_fail  = item_reg.is_last;
                end
            end
            PH_SWALLOW:
            begin
                if (item_reg.is_last)
                    phase_next = PH_OPCODE;
            end
            default:
            begin
                phase_next = PH_OPCODE;
            end
        endcase

        if (do_finish)
        begin
            node_next        = '0;
            pend_next        = '0;
            neg_next         = 1'b0;
            acc_next         = '0;
            phase_next       = PH_OPCODE;
            emit             = 1'b1;
            res.opcode       = pend_reg;
            res.argument     = 32'(num_val);
            res.has_argument = 1'b1;
            res.done_res     = item_reg.is_last;
        end

        if (do_fail)
        begin
            node_next  = '0;
            pend_next  = '0;
            neg_next   = 1'b0;
            acc_next   = '0;
            phase_next = item_reg.is_last ? PH_OPCODE : PH_SWALLOW;
            emit       = 1'b1;
            res        = '0;
            res.error  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
            phase_reg      <= PH_OPCODE;
            node_reg       <= '0;
            pend_reg       <= '0;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            if (item_ready)
                item_vld_reg <= item_valid;
            if (advance)
            begin
                phase_reg <= phase_next;
                node_reg  <= node_next;
                pend_reg  <= pend_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
            if (advance && emit)
                result_vld_reg <= 1'b1;
            else if (result_ready)
                result_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= item;
        if (advance && emit)
            result_reg <= res;
    end

`ifndef SYNTHESIS
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_vld_reg && result_reg.error |->
            result_reg.opcode == '0 && !result_reg.has_argument && !result_reg.done_res)
        else $error("error result carries payload");

    a_swallow_root: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SWALLOW |-> node_reg == '0 && acc_reg == '0)
        else $error("swallow phase with live token state");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_vld_reg |-> item_ready)
        else $error("input stalled with empty output register");
`endif

endmodule
